[rtl/core/crse_pkg.sv]
// ----------------------------------------------------------------------------
// crse_pkg: shared types and constants of the spline evaluator
// Item layouts, queue job layout, field widths and command and status codes.
// ----------------------------------------------------------------------------
package crse_pkg;

    // field widths
    localparam int COORD_W    = 32;              // Q16.16 coordinate
    localparam int FRAC_W     = 16;              // fraction bits of t and u
    localparam int T_W        = FRAC_W + 1;      // t_param, 1.0 included
    localparam int NUM_W      = 7;               // num_points register
    localparam int IDX_W      = 6;               // point_index field
    localparam int CW         = 38;              // Horner intermediates
    localparam int PRODW      = CW + FRAC_W + 1; // intermediate times u

    localparam int NUM_TAPS   = 4;               // control points per segment
    localparam int NUM_AXES   = 3;
    localparam int MIN_POINTS = 4;
    localparam int Q_DEPTH    = 4;               // front to back job queue

    localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_W{1'b0}}};

    localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_FEW = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic                      cmd;
        logic [IDX_W-1:0]          point_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [T_W-1:0]            t_param;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      status;
    } t_out_item;

    // classified job handed from front to back
    typedef struct packed {
        logic              is_wr;   // store write, no result
        logic              err;     // too few points
        logic [FRAC_W-1:0] u;       // local segment parameter
        t_point            wdata;   // point for a store write
    } t_job;

endpackage

[rtl/core/crse_fifo.sv]
// ----------------------------------------------------------------------------
// crse_fifo: small job queue
// Register-based FIFO between the classifying front and the evaluating back.
// ----------------------------------------------------------------------------
module crse_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]   r_count, n_count;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + (PTR_W + 1)'(1);
            2'b01:   n_count = r_count - (PTR_W + 1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (PTR_W + 1)'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

[rtl/core/crse_front.sv]
// ----------------------------------------------------------------------------
// crse_front: item intake and classification
// Holds num_points, splits writes from evaluations, finds the segment, the
// local parameter and the four control point slots, and queues the job.
// ----------------------------------------------------------------------------
module crse_front #(
    parameter int MAX_POINTS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [crse_pkg::NUM_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  crse_pkg::t_in_item           i_in_item,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output crse_pkg::t_job               o_job,
    output logic [crse_pkg::NUM_TAPS-1:0][$clog2(MAX_POINTS)-1:0] o_idx
);
    import crse_pkg::*;

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int SW  = NW + 1;
    localparam int PRW = T_W + NW;

    logic [NUM_W-1:0] r_num_points;
    logic [NW-1:0]    w_n;
    logic [SW-1:0]    w_n_s;
    logic [T_W-1:0]   w_t;
    logic [PRW-1:0]   w_prod;
    logic [SW-1:0]    w_seg, w_sc, w_s1, w_s2, w_i0, w_i2, w_i3;
    logic             w_err, w_is_wr, w_slot_ok;

    // configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= '0;
        end else if (i_cfg_valid) begin
            r_num_points <= i_cfg_data;
        end
    end

    // segment and neighbor slots
    always_comb begin
        w_n   = (int'(r_num_points) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(r_num_points);
        w_n_s = SW'(w_n);
        w_err = (w_n < NW'(MIN_POINTS));
        w_t   = (i_in_item.t_param > T_ONE) ? T_ONE : i_in_item.t_param;
        w_prod = PRW'(w_t) * PRW'(w_n);
        w_seg = SW'(w_prod >> FRAC_W);
        // t of one lands on the last segment with u of zero
        w_sc  = (w_seg >= w_n_s) ? w_n_s - SW'(1) : w_seg;
        w_i0  = (w_sc == '0) ? '0 : w_sc - SW'(1);
        w_s1  = w_sc + SW'(1);
        w_s2  = w_sc + SW'(2);
        w_i2  = (w_s1 >= w_n_s) ? w_s1 - w_n_s : w_s1;
        w_i3  = (w_s2 >= w_n_s) ? w_s2 - w_n_s : w_s2;
    end

    // job build
    always_comb begin
        w_is_wr   = (i_in_item.cmd == CMD_WRITE);
        w_slot_ok = (int'(i_in_item.point_index) < MAX_POINTS);

        o_job.is_wr   = w_is_wr;
        o_job.err     = w_err;
        o_job.u       = w_prod[FRAC_W-1:0];
        o_job.wdata.x = i_in_item.point_x;
        o_job.wdata.y = i_in_item.point_y;
        o_job.wdata.z = i_in_item.point_z;

        o_idx[0] = w_is_wr ? AW'(i_in_item.point_index) : AW'(w_i0);
        o_idx[1] = AW'(w_sc);
        o_idx[2] = AW'(w_i2);
        o_idx[3] = AW'(w_i3);
    end

    // writes to a slot outside the store are taken and dropped
    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full && (!w_is_wr || w_slot_ok);

endmodule

[rtl/core/crse_back.sv]
// ----------------------------------------------------------------------------
// crse_back: point store and cubic evaluation pipeline
// Four store banks give the four control points in a single read; Horner steps
// over three axes follow, one multiply per stage, then round and saturate.
// ----------------------------------------------------------------------------
module crse_back #(
    parameter int MAX_POINTS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    output logic                         o_q_pop,
    input  crse_pkg::t_job               i_job,
    input  logic [crse_pkg::NUM_TAPS-1:0][$clog2(MAX_POINTS)-1:0] i_idx,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output crse_pkg::t_out_item          o_out_item
);
    import crse_pkg::*;

    localparam logic signed [PRODW-1:0] RND_HALF = PRODW'(1) << (FRAC_W - 1);
    localparam logic signed [CW-1:0]    ONE_C    = CW'(1);

    // nearest rounding of a Q.32 product back to Q.16
    function automatic logic signed [CW-1:0] f_rnd(input logic signed [PRODW-1:0] m);
        logic signed [PRODW-1:0] s;
        s = m + RND_HALF;
        f_rnd = CW'(s >>> FRAC_W);
    endfunction

    function automatic logic signed [CW-1:0] f_coord(input t_point p, input int ax);
        case (ax)
            0:       f_coord = CW'(p.x);
            1:       f_coord = CW'(p.y);
            default: f_coord = CW'(p.z);
        endcase
    endfunction

    logic w_adv, w_pop, w_wr;

    // stage valids (result-bearing items only)
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_out_vld;

    // stage payloads
    t_point            r_rd [NUM_TAPS];
    logic              r1_err, r2_err, r3_err, r4_err, r5_err;
    logic [FRAC_W-1:0] r1_u, r2_u, r3_u, r4_u;
    logic signed [CW-1:0]    r2_e3 [NUM_AXES];
    logic signed [CW-1:0]    r2_e2 [NUM_AXES];
    logic signed [CW-1:0]    r2_e1 [NUM_AXES];
    logic signed [CW-1:0]    r2_e0 [NUM_AXES];
    logic signed [PRODW-1:0] r3_m  [NUM_AXES];
    logic signed [CW-1:0]    r3_e2 [NUM_AXES];
    logic signed [CW-1:0]    r3_e1 [NUM_AXES];
    logic signed [CW-1:0]    r3_e0 [NUM_AXES];
    logic signed [PRODW-1:0] r4_m  [NUM_AXES];
    logic signed [CW-1:0]    r4_e1 [NUM_AXES];
    logic signed [CW-1:0]    r4_e0 [NUM_AXES];
    logic signed [PRODW-1:0] r5_m  [NUM_AXES];
    logic signed [CW-1:0]    r5_e0 [NUM_AXES];
    t_out_item               r_out_item;

    logic signed [CW-1:0]      w_e3 [NUM_AXES];
    logic signed [CW-1:0]      w_e2 [NUM_AXES];
    logic signed [CW-1:0]      w_e1 [NUM_AXES];
    logic signed [CW-1:0]      w_e0 [NUM_AXES];
    logic signed [CW-1:0]      w_c  [NUM_AXES];
    logic signed [CW-1:0]      w_c1 [NUM_AXES];
    logic signed [CW-1:0]      w_h  [NUM_AXES];
    logic [COORD_W-1:0]        w_pos [NUM_AXES];

    // whole pipeline moves unless a result is held at the output
    assign w_adv   = !r_out_vld || !i_out_stall;
    assign w_pop   = w_adv && !i_q_empty;
    assign w_wr    = w_pop && i_job.is_wr;
    assign o_q_pop = w_pop;

    // store banks: same write into each, one read slot per bank
    for (genvar k = 0; k < NUM_TAPS; k++) begin : g_bank
        t_point r_mem [MAX_POINTS];
        always_ff @(posedge i_clk) begin
            if (w_wr) begin
                r_mem[i_idx[0]] <= i_job.wdata;
            end
            if (w_adv) begin
                r_rd[k] <= r_mem[i_idx[k]];
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_v1      <= w_pop && !i_job.is_wr;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_v5      <= r_v4;
            r_out_vld <= r_v5;
        end
    end

    // basis coefficients from the four points
    always_comb begin
        logic signed [CW-1:0] p0, p1, p2, p3;
        for (int a = 0; a < NUM_AXES; a++) begin
            p0 = f_coord(r_rd[0], a);
            p1 = f_coord(r_rd[1], a);
            p2 = f_coord(r_rd[2], a);
            p3 = f_coord(r_rd[3], a);
            w_e3[a] = (p3 - p0) + ((p1 - p2) * 3);
            w_e2[a] = (p0 <<< 1) - (p1 * 5) + (p2 <<< 2) - p3;
            w_e1[a] = p2 - p0;
            w_e0[a] = p1 <<< 1;
        end
    end

    // final Horner add, halve, saturate
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_c[a]  = f_rnd(r5_m[a]) + r5_e0[a];
            w_c1[a] = w_c[a] + ONE_C;
            w_h[a]  = w_c1[a] >>> 1;
            if ((w_h[a][CW-1:COORD_W-1] == '0) || (w_h[a][CW-1:COORD_W-1] == '1)) begin
                w_pos[a] = w_h[a][COORD_W-1:0];
            end else begin
                w_pos[a] = w_h[a][CW-1] ? SAT_MIN : SAT_MAX;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_err <= i_job.err;
            r1_u   <= i_job.u;

            r2_err <= r1_err;
            r2_u   <= r1_u;
            r3_err <= r2_err;
            r3_u   <= r2_u;
            r4_err <= r3_err;
            r4_u   <= r3_u;
            r5_err <= r4_err;

            for (int a = 0; a < NUM_AXES; a++) begin
                r2_e3[a] <= w_e3[a];
                r2_e2[a] <= w_e2[a];
                r2_e1[a] <= w_e1[a];
                r2_e0[a] <= w_e0[a];

                r3_m[a]  <= r2_e3[a] * $signed({1'b0, r2_u});
                r3_e2[a] <= r2_e2[a];
                r3_e1[a] <= r2_e1[a];
                r3_e0[a] <= r2_e0[a];

                r4_m[a]  <= (f_rnd(r3_m[a]) + r3_e2[a]) * $signed({1'b0, r3_u});
                r4_e1[a] <= r3_e1[a];
                r4_e0[a] <= r3_e0[a];

                r5_m[a]  <= (f_rnd(r4_m[a]) + r4_e1[a]) * $signed({1'b0, r4_u});
                r5_e0[a] <= r4_e0[a];
            end

            r_out_item.pos_x  <= r5_err ? '0 : w_pos[0];
            r_out_item.pos_y  <= r5_err ? '0 : w_pos[1];
            r_out_item.pos_z  <= r5_err ? '0 : w_pos[2];
            r_out_item.status <= r5_err ? ST_FEW : ST_OK;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

[rtl/core/catmull_rom_spline_eval_unit.sv]
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval_unit: uniform Catmull-Rom curve evaluator
// Usage:
//   cfg channel (valid/ready, always ready) sets num_points; write it only
//   while the unit is idle.
//   in channel (valid/stall): cmd write stores a Q16.16 point in a slot and
//   gives no result; cmd eval samples the curve at t in Q1.16.
//   out channel (valid/stall): one item per eval, position plus status.
// Throughput: one item per cycle while the queue and the out channel do
//   not stall. Each eval passes the job queue, then the back pipeline
//   (bank read, coefficients, three Horner multiplies, round and saturate).
// Store: four banks of MAX_POINTS points, one read per bank per cycle while
//   the pipeline moves; no clearing pass, contents are undefined until written.
// Reset: synchronous, clears num_points, the job queue and all valids.
// Receiver stall: the back pipeline holds with the result in the output
//   register; the 4-deep job queue keeps taking items and raises in stall
//   when full.
// ----------------------------------------------------------------------------
module catmull_rom_spline_eval_unit #(
    parameter int MAX_POINTS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [crse_pkg::NUM_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  crse_pkg::t_in_item         i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output crse_pkg::t_out_item        o_out_item
);
    import crse_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int QW = $bits(t_job) + NUM_TAPS * AW;

    logic                         w_push, w_pop, w_full, w_empty;
    t_job                         w_f_job, w_b_job;
    logic [NUM_TAPS-1:0][AW-1:0]  w_f_idx, w_b_idx;
    logic [QW-1:0]                w_q_din, w_q_dout;

    // intake and classification
    crse_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_q_full    (w_full),
        .o_q_push    (w_push),
        .o_job       (w_f_job),
        .o_idx       (w_f_idx)
    );

    // job queue
    assign w_q_din = {w_f_job, w_f_idx};

    crse_fifo #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_din),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_q_dout),
        .o_empty (w_empty)
    );

    assign {w_b_job, w_b_idx} = w_q_dout;

    // store and evaluation
    crse_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_empty),
        .o_q_pop     (w_pop),
        .i_job       (w_b_job),
        .i_idx       (w_b_idx),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[rtl/core/crse_checker.sv]
// ----------------------------------------------------------------------------
// crse_checker: port-level checks of the spline evaluator
// Watches the top level's channels; attached to it by the bind below.
// ----------------------------------------------------------------------------
module crse_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_stall,
    input logic                i_out_valid,
    input logic                i_out_stall,
    input crse_pkg::t_out_item i_out_item
);
    import crse_pkg::*;

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_item))
        else $error("result changed while stalled");

    // too-few-points results carry a zero position
    a_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_item.status == ST_FEW) |->
            (i_out_item.pos_x == '0) && (i_out_item.pos_y == '0) &&
            (i_out_item.pos_z == '0))
        else $error("error status with nonzero position");

    // reset empties the queue and the pipeline
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_stall)
        else $error("not idle after reset");

endmodule

bind catmull_rom_spline_eval_unit crse_checker u_crse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);
